/* rtl/eav_pkg.sv */
// ----------------------------------------------------------------------------
// Encoder angle and velocity estimator package
// Shared widths, register indexes, fixed-point constants and control structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package eav_pkg;

  // Payload widths.
  localparam int TIME_W  = 32;
  localparam int WHOLE_W = 16;
  localparam int ANG_W   = 20;
  localparam int TOT_W   = 36;
  localparam int VEL_W   = 48;

  // Configuration port.
  localparam int CFG_W  = 16;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [CFG_W-1:0] CPR_RESET  = 16'd4096;
  localparam logic [CFG_W-1:0] GAIN_RESET = 16'd19661;

  typedef enum logic {
    REG_CPR  = 1'b0,
    REG_GAIN = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0] cpr;   // counts per rotation, zero already mapped to one
    logic [CFG_W-1:0] gain;  // filter weight of the new speed, Q0.16
  } cfg_t;

  // Elapsed time handling.
  localparam int DT_W = 19;
  localparam logic [DT_W-1:0] DT_MAX     = 19'd500000;
  localparam logic [DT_W-1:0] DT_DEFAULT = 19'd1000;

  // 2*pi in Q29, and 2*pi * 1e6 * 2^16 split at bit 32.
  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
  localparam logic [31:0] VEL_K_LO   = 32'd3752939171;
  localparam logic [31:0] VEL_K_HI   = 32'd95;

  // Velocity limits as raw 48-bit patterns.
  localparam logic [VEL_W-1:0] VEL_POS_LIM = 48'h7FFF_FFFF_FFFF;
  localparam logic [VEL_W-1:0] VEL_NEG_LIM = 48'h8000_0000_0000;

  localparam int ROUND_HALF = 32768;

  // Shared multiplier: signed 33 x 33.
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  // Shared divider.
  localparam int DIVR_W    = 35;
  localparam int DIV_CNT_W = 7;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

/* rtl/eav_if.sv */
// ----------------------------------------------------------------------------
// Encoder estimator channels
// Valid/ready channels for sample requests and result requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface eav_in_if #(parameter int COUNT_BITS = 16) ();
  import eav_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [COUNT_BITS-1:0] pulse_count;
  logic [TIME_W-1:0]            time_us;

  modport source (output valid, pulse_count, time_us, input ready);
  modport sink   (input valid, pulse_count, time_us, output ready);
endinterface

interface eav_out_if ();
  import eav_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [WHOLE_W-1:0] whole_rotations;
  logic signed [ANG_W-1:0]   angle_in_rotation;
  logic signed [TOT_W-1:0]   total_angle;
  logic signed [VEL_W-1:0]   shaft_velocity;

  modport source (output valid, whole_rotations, angle_in_rotation, total_angle,
                  shaft_velocity, input ready);
  modport sink   (input valid, whole_rotations, angle_in_rotation, total_angle,
                  shaft_velocity, output ready);
endinterface

/* rtl/eav_cfg.sv */
// ----------------------------------------------------------------------------
// Encoder estimator register file
// APB-style write and read access to counts per rotation and filter gain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eav_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [eav_pkg::APB_AW-1:0] paddr,
  input  logic [eav_pkg::APB_DW-1:0] pwdata,
  output logic [eav_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output eav_pkg::cfg_t              cfg
);
  import eav_pkg::*;

  logic [CFG_W-1:0] cpr_r;
  logic [CFG_W-1:0] gain_r;
  reg_idx_t         idx;
  logic             wr_en;

  assign idx    = reg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpr_r  <= CPR_RESET;
      gain_r <= GAIN_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_CPR:  cpr_r  <= pwdata[CFG_W-1:0];
        REG_GAIN: gain_r <= pwdata[CFG_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CPR:  prdata = APB_DW'(cpr_r);
      REG_GAIN: prdata = APB_DW'(gain_r);
      default:  prdata = '0;
    endcase
  end

  // A zero count per rotation behaves as one.
  assign cfg.cpr  = (cpr_r == '0) ? CFG_W'(1) : cpr_r;
  assign cfg.gain = gain_r;

endmodule

/* rtl/eav_div.sv */
// ----------------------------------------------------------------------------
// Encoder estimator shared divider
// Restoring divider, one quotient bit per cycle over a chosen dividend width.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module eav_div #(
  parameter int DW = 57
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  eav_pkg::div_req_t          req,
  input  logic [DW-1:0]              dividend,
  input  logic [eav_pkg::DIVR_W-1:0] divisor,
  output logic [DW-1:0]              quot,
  output logic [eav_pkg::DIVR_W-1:0] rem,
  output eav_pkg::div_sts_t          sts
);
  import eav_pkg::*;

  logic [DW-1:0]        dvd_r;
  logic [DW-1:0]        q_r;
  logic [DIVR_W-1:0]    d_r;
  logic [DIVR_W-1:0]    rem_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [DIVR_W:0]      rem_sh;
  logic [DIVR_W:0]      rem_sub;
  logic                 fits;
  logic [DIV_CNT_W-1:0] align;

  // Only the low nbits of the dividend are significant, so they are moved to the top.
  assign align   = DIV_CNT_W'(DW) - req.nbits;
  assign rem_sh  = {rem_r, dvd_r[DW-1]};
  assign rem_sub = rem_sh - {1'b0, d_r};
  assign fits    = (rem_sh >= {1'b0, d_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == DIV_CNT_W'(1))) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= dividend << align;
      q_r   <= '0;
      rem_r <= '0;
      d_r   <= divisor;
      cnt_r <= req.nbits;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DW-2:0], 1'b0};
      q_r   <= {q_r[DW-2:0], fits};
      rem_r <= fits ? rem_sub[DIVR_W-1:0] : rem_sh[DIVR_W-1:0];
      cnt_r <= cnt_r - DIV_CNT_W'(1);
    end
  end

  assign quot     = q_r;
  assign rem      = rem_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

/* rtl/encoder_angle_velocity_estimator_unit.sv */
// ----------------------------------------------------------------------------
// Encoder angle and velocity estimator
// An accepted sample request is worked through the shared multiplier and the shared
// divider's bit-serial passes before the next one can be taken.
// The result request is then presented from the output register and waits there while
// a new sample is taken.
// Synchronous active-low reset restores the register defaults and clears the previous
// count, previous time and filtered velocity to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module encoder_angle_velocity_estimator_unit #(
  parameter int COUNT_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  eav_in_if.sink                     in_ch,
  eav_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [eav_pkg::APB_AW-1:0] paddr,
  input  logic [eav_pkg::APB_DW-1:0] pwdata,
  output logic [eav_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import eav_pkg::*;

  // Dividend width: the velocity dividend needs COUNT_BITS + 40 bits and the in-rotation
  // angle needs 49, which the extra bit covers at the smallest counter width.
  localparam int DW = COUNT_BITS + 41;

  // Significant dividend bits of each division pass.
  localparam logic [DIV_CNT_W-1:0] N_Q   = DIV_CNT_W'(COUNT_BITS);
  localparam logic [DIV_CNT_W-1:0] N_REM = DIV_CNT_W'(49);
  localparam logic [DIV_CNT_W-1:0] N_TOT = DIV_CNT_W'(COUNT_BITS + 32);
  localparam logic [DIV_CNT_W-1:0] N_VEL = DIV_CNT_W'(COUNT_BITS + 40);

  // The sequencer walks through the multiply steps and the four division passes.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAG,
    ST_MUL_DVEL,
    ST_DIV_Q,
    ST_MUL_REM,
    ST_DIV_REM,
    ST_MUL_TOT,
    ST_DIV_TOT,
    ST_MUL_VLO,
    ST_MUL_VHI,
    ST_DIV_VEL,
    ST_FILT_LO,
    ST_FILT_HI,
    ST_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;

  cfg_t cfg;

  // Sample and history.
  logic signed [COUNT_BITS-1:0] count_r;
  logic [TIME_W-1:0]            time_r;
  logic signed [COUNT_BITS-1:0] last_count_r;
  logic [TIME_W-1:0]            last_time_r;
  logic signed [VEL_W-1:0]      filt_r;

  // Intermediate values of one request.
  logic [COUNT_BITS-1:0] cm_r;
  logic [COUNT_BITS-1:0] dnm_r;
  logic                  dn_neg_r;
  logic [DT_W-1:0]       dt_r;
  logic [DIVR_W-1:0]     dvel_r;
  logic [DW-1:0]         acc_r;
  logic [CFG_W-1:0]      rmag_r;
  logic [VEL_W:0]        diff_r;
  logic signed [PROD_W-1:0] facc_r;
  logic signed [WHOLE_W-1:0] whole_r;
  logic signed [ANG_W-1:0]   angr_r;
  logic signed [TOT_W-1:0]   angt_r;

  // Output register. It holds a finished result while the next request is worked on.
  logic                      out_valid_r;
  logic signed [WHOLE_W-1:0] out_whole_r;
  logic signed [ANG_W-1:0]   out_angr_r;
  logic signed [TOT_W-1:0]   out_angt_r;
  logic signed [VEL_W-1:0]   vel_r;

  // Shared multiplier and divider.
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;

  div_req_t              div_req;
  div_sts_t              div_sts;
  logic                  div_start_r;
  logic                  div_start_nxt;
  logic [DW-1:0]         div_dividend;
  logic [DIVR_W-1:0]     div_divisor;
  logic [DW-1:0]         div_quot;
  logic [DIVR_W-1:0]     div_rem;

  // Combinational helpers.
  logic                  neg;
  logic [COUNT_BITS-1:0] cm;
  logic signed [COUNT_BITS:0] dn;
  logic [COUNT_BITS:0]   dn_abs;
  logic [TIME_W-1:0]     dt_raw;
  logic                  dt_bad;
  logic [VEL_W-1:0]      vraw;
  logic signed [VEL_W+1:0] vsum;
  logic [VEL_W-1:0]      vnew;
  logic                  out_free;
  logic                  is_div_nxt;

  eav_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  eav_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quot     (div_quot),
    .rem      (div_rem),
    .sts      (div_sts)
  );

  // The sign of the count sets the sign of the quotient and both angles.
  assign neg    = count_r[COUNT_BITS-1];
  assign cm     = neg ? COUNT_BITS'(-count_r) : COUNT_BITS'(count_r);
  assign dn     = $signed({count_r[COUNT_BITS-1], count_r})
                - $signed({last_count_r[COUNT_BITS-1], last_count_r});
  assign dn_abs = dn[COUNT_BITS] ? (COUNT_BITS + 1)'(-dn) : (COUNT_BITS + 1)'(dn);

  // The elapsed time wraps at 32 bits; a zero, negative or overlong gap uses 1 ms.
  assign dt_raw = time_r - last_time_r;
  assign dt_bad = (dt_raw == '0) || dt_raw[TIME_W-1] || (dt_raw > TIME_W'(DT_MAX));

  assign out_free = !out_valid_r || out_ch.ready;

  // Raw speed saturates to 48 bits before it enters the filter.
  always_comb begin
    if (dn_neg_r) begin
      vraw = (div_quot > DW'(VEL_NEG_LIM)) ? VEL_NEG_LIM : VEL_W'(-div_quot);
    end else begin
      vraw = (div_quot > DW'(VEL_POS_LIM)) ? VEL_POS_LIM : div_quot[VEL_W-1:0];
    end
  end

  // The filter is old + floor((g * (raw - old) + 2^15) / 2^16), the same as the
  // weighted sum of raw and old speed with round-half-up.
  assign vsum = $signed(facc_r[PROD_W-1:16]) + (VEL_W + 2)'(filt_r);

  always_comb begin
    if (vsum > $signed({2'b00, VEL_POS_LIM})) begin
      vnew = VEL_POS_LIM;
    end else if (vsum < $signed({2'b11, VEL_NEG_LIM})) begin
      vnew = VEL_NEG_LIM;
    end else begin
      vnew = vsum[VEL_W-1:0];
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (state_r)
      ST_MUL_DVEL: begin
        mul_a = $signed(MUL_W'(dt_r));
        mul_b = $signed(MUL_W'(cfg.cpr));
      end
      ST_MUL_REM: begin
        mul_a = $signed(MUL_W'(rmag_r));
        mul_b = $signed(MUL_W'(TWO_PI_Q29));
      end
      ST_MUL_TOT: begin
        mul_a = $signed(MUL_W'(cm_r));
        mul_b = $signed(MUL_W'(TWO_PI_Q29));
      end
      ST_MUL_VLO: begin
        mul_a = $signed(MUL_W'(dnm_r));
        mul_b = $signed(MUL_W'(VEL_K_LO));
      end
      ST_MUL_VHI: begin
        mul_a = $signed(MUL_W'(dnm_r));
        mul_b = $signed(MUL_W'(VEL_K_HI));
      end
      ST_FILT_LO: begin
        mul_a = $signed(MUL_W'(cfg.gain));
        mul_b = $signed(MUL_W'(diff_r[23:0]));
      end
      ST_FILT_HI: begin
        mul_a = $signed(MUL_W'(cfg.gain));
        mul_b = $signed({{(MUL_W - 25){diff_r[VEL_W]}}, diff_r[VEL_W:24]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Operand selection for the shared divider. The whole rotations divide by cpr, the angles
  // by cpr * 2^13 and the speed by the elapsed time times cpr.
  always_comb begin
    div_req.start = div_start_r;
    unique case (state_r)
      ST_DIV_Q: begin
        div_dividend = DW'(cm_r);
        div_divisor  = DIVR_W'(cfg.cpr);
        div_req.nbits = N_Q;
      end
      ST_DIV_REM: begin
        div_dividend = acc_r;
        div_divisor  = DIVR_W'({cfg.cpr, 13'b0});
        div_req.nbits = N_REM;
      end
      ST_DIV_TOT: begin
        div_dividend = acc_r;
        div_divisor  = DIVR_W'({cfg.cpr, 13'b0});
        div_req.nbits = N_TOT;
      end
      default: begin
        div_dividend = acc_r;
        div_divisor  = dvel_r;
        div_req.nbits = N_VEL;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_ch.valid) state_nxt = ST_MAG;
      ST_MAG:      state_nxt = ST_MUL_DVEL;
      ST_MUL_DVEL: state_nxt = ST_DIV_Q;
      ST_DIV_Q:    if (div_sts.done) state_nxt = ST_MUL_REM;
      ST_MUL_REM:  state_nxt = ST_DIV_REM;
      ST_DIV_REM:  if (div_sts.done) state_nxt = ST_MUL_TOT;
      ST_MUL_TOT:  state_nxt = ST_DIV_TOT;
      ST_DIV_TOT:  if (div_sts.done) state_nxt = ST_MUL_VLO;
      ST_MUL_VLO:  state_nxt = ST_MUL_VHI;
      ST_MUL_VHI:  state_nxt = ST_DIV_VEL;
      ST_DIV_VEL:  if (div_sts.done) state_nxt = ST_FILT_LO;
      ST_FILT_LO:  state_nxt = ST_FILT_HI;
      ST_FILT_HI:  state_nxt = ST_FINISH;
      ST_FINISH:   if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // A division pass starts on the first cycle of its state.
  assign is_div_nxt    = (state_nxt == ST_DIV_Q) || (state_nxt == ST_DIV_REM)
                      || (state_nxt == ST_DIV_TOT) || (state_nxt == ST_DIV_VEL);
  assign div_start_nxt = is_div_nxt && (state_nxt != state_r);

  // State, history and the output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      div_start_r  <= 1'b0;
      out_valid_r  <= 1'b0;
      last_count_r <= '0;
      last_time_r  <= '0;
      filt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      div_start_r <= div_start_nxt;
      if ((state_r == ST_FINISH) && out_free) begin
        out_valid_r  <= 1'b1;
        last_count_r <= count_r;
        last_time_r  <= time_r;
        filt_r       <= $signed(vnew);
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers of the request in flight.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          count_r <= in_ch.pulse_count;
          time_r  <= in_ch.time_us;
        end
      end
      ST_MAG: begin
        cm_r     <= cm;
        dnm_r    <= dn_abs[COUNT_BITS-1:0];
        dn_neg_r <= dn[COUNT_BITS];
        dt_r     <= dt_bad ? DT_DEFAULT : dt_raw[DT_W-1:0];
      end
      ST_MUL_DVEL: begin
        dvel_r <= prod[DIVR_W-1:0];
      end
      ST_DIV_Q: begin
        if (div_sts.done) begin
          whole_r <= neg ? WHOLE_W'(-div_quot) : div_quot[WHOLE_W-1:0];
          rmag_r  <= div_rem[CFG_W-1:0];
        end
      end
      ST_MUL_REM, ST_MUL_TOT: begin
        // Half the divisor is added first so that the quotient rounds half up.
        acc_r <= DW'(prod) + DW'({cfg.cpr, 12'b0});
      end
      ST_DIV_REM: begin
        if (div_sts.done) begin
          angr_r <= neg ? ANG_W'(-div_quot) : div_quot[ANG_W-1:0];
        end
      end
      ST_DIV_TOT: begin
        if (div_sts.done) begin
          angt_r <= neg ? TOT_W'(-div_quot) : div_quot[TOT_W-1:0];
        end
      end
      ST_MUL_VLO: begin
        acc_r <= DW'(prod) + DW'(dvel_r[DIVR_W-1:1]);
      end
      ST_MUL_VHI: begin
        acc_r <= acc_r + DW'({prod, 32'b0});
      end
      ST_DIV_VEL: begin
        if (div_sts.done) begin
          diff_r <= (VEL_W + 1)'($signed(vraw)) - (VEL_W + 1)'(filt_r);
        end
      end
      ST_FILT_LO: begin
        facc_r <= prod;
      end
      ST_FILT_HI: begin
        facc_r <= facc_r + PROD_W'({prod, 24'b0}) + PROD_W'(ROUND_HALF);
      end
      ST_FINISH: begin
        if (out_free) begin
          out_whole_r <= whole_r;
          out_angr_r  <= angr_r;
          out_angt_r  <= angt_r;
          vel_r       <= $signed(vnew);
        end
      end
      default: ;
    endcase
  end

  assign in_ch.ready              = (state_r == ST_IDLE);
  assign out_ch.valid             = out_valid_r;
  assign out_ch.whole_rotations   = out_whole_r;
  assign out_ch.angle_in_rotation = out_angr_r;
  assign out_ch.total_angle       = out_angt_r;
  assign out_ch.shaft_velocity    = vel_r;

  // A new sample is never taken while the divider still works on the last one.
  a_ready_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (!div_sts.busy && !div_start_r))
    else $error("sample accepted while the divider is busy");

  // The divider only finishes inside one of the four division passes.
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> ((state_r == ST_DIV_Q) || (state_r == ST_DIV_REM)
                   || (state_r == ST_DIV_TOT) || (state_r == ST_DIV_VEL)))
    else $error("divider finished outside a division pass");

  // Completing a request presents the result and moves the history forward.
  a_finish_updates: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FINISH) && out_free) |=>
      (out_valid_r && (last_time_r == $past(time_r)) && (state_r == ST_IDLE)))
    else $error("finished request did not update the result and history");

  // The count per rotation, a factor of every divisor, is never zero when a division starts.
  a_cpr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start_r |-> (cfg.cpr != '0))
    else $error("division started with a zero count per rotation");

endmodule
